// ----- hdl/phfe_pkg.sv -----
// Package for the PPP async HDLC frame encoder: item, result and queue entry types,
// framing constants, FCS and octet-stuffing helper functions.
// No dependencies.
package phfe_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [15:0] FCS_INIT = 16'hFFFF;
	localparam logic [15:0] FCS_POLY = 16'h8408;
	localparam logic [31:0] ACCM_RESET = 32'hFFFF_FFFF;
	localparam int unsigned MAX_BYTES = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic       escape_all_control;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                last_idx;
		logic                      close;
	} entry_t;

	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] c;
		c = fcs ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b, input logic [31:0] accm,
		input logic all_ctl);
		logic esc;
		esc = (b == ESC_BYTE) || (b == FLAG_BYTE);
		if (b[7:5] == 3'b000 && (all_ctl || accm[b[4:0]])) begin
			esc = 1'b1;
		end
		return esc;
	endfunction

endpackage

// ----- hdl/phfe_front.sv -----
// Front end of the PPP async HDLC frame encoder: ACCM register, running FCS,
// and expansion of one payload byte into its list of stream bytes.
// Depends on phfe_pkg.
module phfe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	input  logic            take,
	input  phfe_pkg::item_t item,
	output phfe_pkg::entry_t entry
);

	logic [31:0] accm_q;
	logic [15:0] fcs_q;
	logic [15:0] fcs_base;
	logic [15:0] fcs_new;
	logic [15:0] fcs_tx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accm_q <= phfe_pkg::ACCM_RESET;
			fcs_q <= phfe_pkg::FCS_INIT;
		end else begin
			if (cfg_we) begin
				accm_q <= cfg_wdata;
			end
			if (take) begin
				fcs_q <= item.last_byte ? phfe_pkg::FCS_INIT : fcs_new;
			end
		end
	end

	assign fcs_base = item.first_byte ? phfe_pkg::FCS_INIT : fcs_q;
	assign fcs_new = phfe_pkg::fcs_update(fcs_base, item.data_byte);
	assign fcs_tx = ~fcs_new;

	always_comb begin
		logic [3:0] n;
		logic [7:0] b;
		n = '0;
		entry.bytes = '0;
		if (item.first_byte) begin
			entry.bytes[n[2:0]] = phfe_pkg::FLAG_BYTE;
			n = n + 4'd1;
		end
		b = item.data_byte;
		if (phfe_pkg::needs_escape(b, accm_q, item.escape_all_control)) begin
			entry.bytes[n[2:0]] = phfe_pkg::ESC_BYTE;
			n = n + 4'd1;
			b = b ^ phfe_pkg::ESC_XOR;
		end
		entry.bytes[n[2:0]] = b;
		n = n + 4'd1;
		if (item.last_byte) begin
			b = fcs_tx[7:0];
			if (phfe_pkg::needs_escape(b, accm_q, item.escape_all_control)) begin
				entry.bytes[n[2:0]] = phfe_pkg::ESC_BYTE;
				n = n + 4'd1;
				b = b ^ phfe_pkg::ESC_XOR;
			end
			entry.bytes[n[2:0]] = b;
			n = n + 4'd1;
			b = fcs_tx[15:8];
			if (phfe_pkg::needs_escape(b, accm_q, item.escape_all_control)) begin
				entry.bytes[n[2:0]] = phfe_pkg::ESC_BYTE;
				n = n + 4'd1;
				b = b ^ phfe_pkg::ESC_XOR;
			end
			entry.bytes[n[2:0]] = b;
			n = n + 4'd1;
			entry.bytes[n[2:0]] = phfe_pkg::FLAG_BYTE;
			n = n + 4'd1;
		end
		entry.last_idx = 3'(n - 4'd1);
		entry.close = item.last_byte;
	end

endmodule

// ----- hdl/phfe_queue.sv -----
// Entry queue between front and back ends of the PPP async HDLC frame encoder.
// Register-based ring buffer with the head visible combinationally. Depends on phfe_pkg.
module phfe_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  phfe_pkg::entry_t  wr_data,
	input  logic              rd_en,
	output phfe_pkg::entry_t  head,
	output logic              q_empty,
	output logic              q_full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	phfe_pkg::entry_t  slots_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	assign head = slots_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full = (count_q == CW'(DEPTH));

endmodule

// ----- hdl/phfe_back.sv -----
// Back end of the PPP async HDLC frame encoder: walks the head entry one stream
// byte per cycle into the result register, while that register is empty or popped. Depends on phfe_pkg.
module phfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  phfe_pkg::entry_t  head,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output phfe_pkg::result_t result
);

	logic [2:0]        idx_q;
	logic              out_valid_q;
	phfe_pkg::result_t res_q;
	logic              load;
	logic              done;

	assign load = !q_empty && (!out_valid_q || pop);
	assign done = (idx_q == head.last_idx);
	assign q_pop = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= done ? 3'd0 : idx_q + 3'd1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte <= head.bytes[idx_q];
			res_q.run_last <= done;
			res_q.frame_end <= done && head.close;
		end
	end

	assign empty = !out_valid_q;
	assign result = res_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_end |-> res_q.run_last)
		else $error("closing flag not marked as final byte of its transaction");

	a_end_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_end |-> res_q.out_byte == phfe_pkg::FLAG_BYTE)
		else $error("frame end on a byte other than the flag");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx_q <= head.last_idx)
		else $error("byte index past end of entry");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> idx_q == 3'd0)
		else $error("byte index not cleared after entry retired");

endmodule

// ----- hdl/ppp_async_hdlc_frame_encoder_unit.sv -----
// Path: an accepted transaction is written into a queue slot, then moved into the result register.
// Throughput: one stream byte per cycle from the back end while pop keeps the result
// register draining; an input byte expands there to 1 to 8 stream bytes (flags, escapes,
// FCS). Front accepts one per cycle until the DEPTH-entry queue fills.
// Reset (arst_n low): queue and result register empty, FCS = 0xFFFF, ACCM = 0xFFFFFFFF.
module ppp_async_hdlc_frame_encoder_unit #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  phfe_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output phfe_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);

	phfe_pkg::entry_t entry;
	phfe_pkg::entry_t head;
	logic             take;
	logic             q_empty;
	logic             q_pop;

	assign take = push && !full;

	phfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item      (item),
		.entry     (entry)
	);

	phfe_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (entry),
		.rd_en   (q_pop),
		.head    (head),
		.q_empty (q_empty),
		.q_full  (full)
	);

	phfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for ppp_async_hdlc_frame_encoder_unit: random and directed PPP frames through
// a predictor of the flag, octet-stuffing and FCS stream. Depends on phfe_pkg and the DUT.
module tb;

	localparam int STALL_LIMIT = 4000;
	localparam int PRESSURE_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	phfe_pkg::item_t   item = '0;
	logic              empty;
	logic              pop = 1'b0;
	phfe_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic [31:0]       cfg_wdata = '0;

	phfe_pkg::item_t   pending_bytes[$];
	phfe_pkg::result_t stream_q[$];

	logic [31:0] accm_shadow = phfe_pkg::ACCM_RESET;
	logic [15:0] fcs_acc = phfe_pkg::FCS_INIT;
	logic [7:0]  burst_byte[8];
	logic        burst_close[8];
	int          burst_len;

	int tx_gap, tx_burst, rx_gap, rx_burst, rx_hold;
	int items_accepted, results_seen, frames_closed, accm_settings, mismatches, idle_cycles;
	phfe_pkg::result_t exp_res;

	ppp_async_hdlc_frame_encoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			burst = $urandom_range(20, 60);
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", what);
		end
	endtask

	task automatic emit_raw(input logic [7:0] b, input logic close);
		burst_byte[3'(burst_len)] = b;
		burst_close[3'(burst_len)] = close;
		burst_len++;
	endtask

	task automatic emit_stuffed(input logic [7:0] b, input logic all_ctl);
		logic esc;
		esc = (b == phfe_pkg::ESC_BYTE) || (b == phfe_pkg::FLAG_BYTE);
		if (b < 8'h20 && (all_ctl || accm_shadow[b[4:0]])) begin
			esc = 1'b1;
		end
		if (esc) begin
			emit_raw(phfe_pkg::ESC_BYTE, 1'b0);
			emit_raw(b ^ phfe_pkg::ESC_XOR, 1'b0);
		end else begin
			emit_raw(b, 1'b0);
		end
	endtask

	// Expected stream bytes for one accepted payload byte
	task automatic encode_item(input phfe_pkg::item_t it);
		logic        fb;
		logic [15:0] inv;
		burst_len = 0;
		if (it.first_byte) begin
			fcs_acc = phfe_pkg::FCS_INIT;
			emit_raw(phfe_pkg::FLAG_BYTE, 1'b0);
		end
		for (int i = 0; i < 8; i++) begin
			fb = fcs_acc[0] ^ it.data_byte[3'(i)];
			fcs_acc = fcs_acc >> 1;
			if (fb) begin
				fcs_acc = fcs_acc ^ phfe_pkg::FCS_POLY;
			end
		end
		emit_stuffed(it.data_byte, it.escape_all_control);
		if (it.last_byte) begin
			inv = ~fcs_acc;
			emit_stuffed(inv[7:0], it.escape_all_control);
			emit_stuffed(inv[15:8], it.escape_all_control);
			emit_raw(phfe_pkg::FLAG_BYTE, 1'b1);
			fcs_acc = phfe_pkg::FCS_INIT;
		end
		for (int i = 0; i < burst_len; i++) begin
			stream_q.push_back('{out_byte: burst_byte[3'(i)], run_last: (i == burst_len - 1),
				frame_end: burst_close[3'(i)]});
		end
	endtask

	task automatic add_item(input logic [7:0] d, input logic f, input logic l, input logic eac);
		pending_bytes.push_back('{data_byte: d, first_byte: f, last_byte: l,
			escape_all_control: eac});
	endtask

	// Mostly well-formed frames; some abandoned, some without opening, some with random marks
	task automatic random_traffic(input int count);
		int          added, len, kind;
		logic        f, l, eac;
		logic [7:0]  d;
		added = 0;
		while (added < count) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			kind = $urandom_range(0, 99);
			eac = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				f = (k == 0);
				l = (k == len - 1);
				if (kind >= 80 && kind < 88) begin
					l = 1'b0;
				end else if (kind >= 88 && kind < 94) begin
					f = 1'b0;
				end else if (kind >= 94) begin
					f = 1'($urandom_range(0, 1));
					l = 1'($urandom_range(0, 1));
					eac = 1'($urandom_range(0, 1));
				end
				case ($urandom_range(0, 7))
					0: d = phfe_pkg::ESC_BYTE;
					1: d = phfe_pkg::FLAG_BYTE;
					2: d = 8'($urandom_range(0, 31));
					default: d = 8'($urandom_range(0, 255));
				endcase
				add_item(d, f, l, eac);
			end
			added += len;
		end
	endtask

	task automatic settle();
		while (pending_bytes.size() != 0 || stream_q.size() != 0 || push) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			tx_gap = 0;
			tx_burst = 0;
		end else begin
			if (push && !full) begin
				encode_item(item);
				void'(pending_bytes.pop_front());
				items_accepted++;
				tx_gap = pick_gap(tx_burst);
			end
			if (!push || !full) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					push <= 1'b1;
					item <= pending_bytes[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_gap = 0;
			rx_burst = 0;
			rx_hold = 0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (result.frame_end) begin
					frames_closed++;
				end
				if (stream_q.size() == 0) begin
					log_mismatch($sformatf("unexpected transaction: byte %02h run_last %0b end %0b",
						result.out_byte, result.run_last, result.frame_end));
				end else begin
					exp_res = stream_q.pop_front();
					if (result.out_byte !== exp_res.out_byte ||
						result.run_last !== exp_res.run_last ||
						result.frame_end !== exp_res.frame_end) begin
						log_mismatch($sformatf(
							"mismatch: exp byte %02h run_last %0b end %0b, got %02h %0b %0b",
							exp_res.out_byte, exp_res.run_last, exp_res.frame_end,
							result.out_byte, result.run_last, result.frame_end));
					end
				end
				// hold off long enough to back up the input
				if (results_seen == 120 || results_seen == 600) begin
					rx_hold = PRESSURE_CYCLES;
				end
				rx_gap = pick_gap(rx_burst);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] accm_plan[$];
		int          share[$];
		accm_plan = '{32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'hFFFF_FFFF, 32'h0};
		accm_plan[2] = $urandom;
		accm_plan[4] = $urandom;
		share = '{80, 70, 60, 60, 50};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset map: one-byte frame, specials, abandoned frame, frame without opening
		add_item(8'h00, 1'b1, 1'b1, 1'b0);
		add_item(phfe_pkg::FLAG_BYTE, 1'b1, 1'b0, 1'b0);
		add_item(phfe_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0);
		add_item(8'h1F, 1'b0, 1'b0, 1'b0);
		add_item(8'h20, 1'b0, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0, 1'b1);
		add_item(8'hFF, 1'b0, 1'b1, 1'b0);
		add_item(8'h11, 1'b1, 1'b0, 1'b0);
		add_item(8'h55, 1'b1, 1'b0, 1'b0);
		add_item(phfe_pkg::FLAG_BYTE, 1'b0, 1'b1, 1'b0);
		add_item(8'h03, 1'b0, 1'b0, 1'b0);
		add_item(8'hAA, 1'b0, 1'b1, 1'b0);
		random_traffic(80);

		for (int p = 0; p < 5; p++) begin
			settle();
			cfg_we <= 1'b1;
			cfg_wdata <= accm_plan[p];
			accm_shadow = accm_plan[p];
			accm_settings++;
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			if (p == 0) begin
				// empty map: control bytes pass unless all-control escaping is on
				add_item(8'h01, 1'b1, 1'b0, 1'b0);
				add_item(8'h1F, 1'b0, 1'b0, 1'b0);
				add_item(phfe_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0);
				add_item(8'h80, 1'b0, 1'b1, 1'b0);
				add_item(8'h01, 1'b1, 1'b0, 1'b1);
				add_item(8'h1F, 1'b0, 1'b0, 1'b1);
				add_item(8'h00, 1'b0, 1'b0, 1'b1);
				add_item(8'hFF, 1'b0, 1'b1, 1'b1);
				add_item(8'hFF, 1'b1, 1'b1, 1'b1);
			end
			random_traffic(share[p]);
		end

		settle();
		repeat (8) @(posedge clk);
		if (stream_q.size() != 0) begin
			log_mismatch($sformatf("%0d expected stream bytes never arrived", stream_q.size()));
		end
		$display("Run covered %0d payload bytes, %0d stream bytes, %0d closed frames",
			items_accepted, results_seen, frames_closed);
		$display("over %0d written ACCM settings plus the reset map; %0d mismatches",
			accm_settings, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
